FILE: rtl/m4ra_pkg.sv
// ----------------------------------------------------------------------------
// m4ra_pkg
// shared types and constants of the m4' remesh accumulator
// ----------------------------------------------------------------------------
package m4ra_pkg;

    // fixed-point fraction bits of coordinates, weights and sums
    localparam int FRAC_BITS = 16;

    localparam int COORD_W = 32;               // coordinate and value fields
    localparam int SUM_W   = 40;               // accumulator and result
    localparam int MUL_W   = 32;               // shared multiplier operands
    localparam int PROD_W  = 2 * MUL_W;        // shared multiplier product
    localparam int R_W     = FRAC_BITS + 1;    // scaled distance below 2.0
    localparam int W_W     = FRAC_BITS + 3;    // signed kernel weight
    localparam int WX_W    = FRAC_BITS + 4;    // weight arithmetic headroom
    localparam int WMAG_W  = FRAC_BITS + 2;    // weight magnitude

    localparam logic [31:0]    INV_SPACING_RESET = 32'(64'd1 << FRAC_BITS);
    localparam logic [R_W-1:0] ONE_R             = R_W'(64'd1 << FRAC_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_D,
        ST_MUL_SQ,
        ST_MUL_CUBE,
        ST_WEIGHT,
        ST_MUL_V,
        ST_MUL_W,
        ST_ACCUM
    } state_t;

    // request to the shared multiplier
    typedef struct packed {
        logic             en;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_req_t;

endpackage

FILE: rtl/m4ra_mul.sv
// ----------------------------------------------------------------------------
// m4ra_mul
// shared unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module m4ra_mul (
    input  logic                       aclk,
    input  m4ra_pkg::mul_req_t         req,
    output logic [m4ra_pkg::PROD_W-1:0] prod
);
    import m4ra_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    // product holds while no request is issued
    always_ff @(posedge aclk) begin
        if (req.en) begin
            prod_reg <= PROD_W'(req.a) * PROD_W'(req.b);
        end
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/m4_kernel_remesh_accumulator_unit.sv
// ----------------------------------------------------------------------------
// m4_kernel_remesh_accumulator_unit
// separable 2-d m4' kernel weighting and saturating accumulation per grid point
// ----------------------------------------------------------------------------
// output: a result is registered out of the accumulate step of the request
//   carrying tlast
// sequencing: no new request is accepted until eleven sequencer steps around the
//   shared 32x32 multiplier are done (4 per axis weight, 3 for the value products and
//   the sum); a result still waiting at the output holds the sum step
// reset: aresetn low clears the sequencer, accumulator, clip flag and output
//   valid, and loads inv_spacing with 1.0; the block is ready next cycle
module m4_kernel_remesh_accumulator_unit (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration: inv_spacing, unsigned q16.16
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data,
    // input requests
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata fields from bit 0: grid_x[31:0], grid_y[63:32], particle_x[95:64],
    // particle_y[127:96], particle_value[159:128]
    input  logic [159:0] s_tdata,
    input  logic         s_tlast,  // last_neighbor
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,  // interpolated_value[39:0]
    output logic         m_tuser   // saturated[0]
);
    import m4ra_pkg::*;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t                state_reg, state_next;
    logic                  axis_reg, axis_next;      // 0 = x weight, 1 = y weight
    logic [31:0]           inv_reg;
    logic [COORD_W-1:0]    dx_reg, dx_next;
    logic [COORD_W-1:0]    dy_reg, dy_next;
    logic [COORD_W-1:0]    v_reg, v_next;
    logic                  last_reg, last_next;
    logic                  big_reg, big_next;        // scaled distance at or past 2.0
    logic                  inner_reg, inner_next;    // scaled distance at or below 1.0
    logic [R_W-1:0]        r_reg, r_next;
    logic [R_W-1:0]        sq_reg, sq_next;
    logic [W_W-1:0]        wx_reg, wx_next;
    logic [W_W-1:0]        wy_reg, wy_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic                  clip_reg, clip_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [SUM_W-1:0]      out_data_reg, out_data_next;
    logic                  out_sat_reg, out_sat_next;

    mul_req_t              mul_req;
    logic [PROD_W-1:0]     prod;

    m4ra_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (prod)
    );

    // ------------------------------------------------------------------
    // datapath helpers
    // ------------------------------------------------------------------
    logic [COORD_W:0]      diff_x, diff_y;
    logic [63-2*FRAC_BITS-1:0] r_hi;
    logic [R_W-1:0]        prod_frac;    // product >> frac, below 2.0
    logic [R_W:0]          t_wide;
    logic [WX_W-1:0]       five_sq, three_p, w_calc;
    logic [W_W-1:0]        wx_mag, wy_mag;
    logic [COORD_W-1:0]    v_mag, prod_q;
    logic                  term_neg;
    logic [COORD_W:0]      term;
    logic [SUM_W:0]        sum_wide;
    logic [SUM_W-1:0]      sum_sat;
    logic                  sum_ovf;

    // exact distances from the 33-bit difference
    assign diff_x = {s_tdata[31], s_tdata[31:0]} - {s_tdata[95], s_tdata[95:64]};
    assign diff_y = {s_tdata[63], s_tdata[63:32]} - {s_tdata[127], s_tdata[127:96]};

    assign r_hi      = prod[63:2*FRAC_BITS+1];
    assign prod_frac = prod[2*FRAC_BITS:FRAC_BITS];
    assign t_wide    = (R_W+1)'(ONE_R) + (R_W+1)'(ONE_R) - (R_W+1)'(prod_frac);

    // 5*sq and 3*p, halved below to 2.5*sq and 1.5*p
    assign five_sq = (WX_W'(sq_reg) << 2) + WX_W'(sq_reg);
    assign three_p = (WX_W'(prod_frac) << 1) + WX_W'(prod_frac);

    always_comb begin
        if (big_reg) begin
            w_calc = '0;
        end else if (inner_reg) begin
            w_calc = WX_W'(ONE_R) - (five_sq >> 1) + (three_p >> 1);
        end else begin
            w_calc = WX_W'(0) - WX_W'(prod_frac >> 1);
        end
    end

    assign wx_mag = wx_reg[W_W-1] ? (W_W'(0) - wx_reg) : wx_reg;
    assign wy_mag = wy_reg[W_W-1] ? (W_W'(0) - wy_reg) : wy_reg;
    assign v_mag  = v_reg[COORD_W-1] ? (COORD_W'(0) - v_reg) : v_reg;

    // magnitude products stay within 2^31 since every weight is at most 1.0
    assign prod_q   = prod[FRAC_BITS+COORD_W-1:FRAC_BITS];
    assign term_neg = v_reg[COORD_W-1] ^ wx_reg[W_W-1] ^ wy_reg[W_W-1];
    assign term     = term_neg ? ((COORD_W+1)'(0) - {1'b0, prod_q}) : {1'b0, prod_q};
    assign sum_wide = {sum_reg[SUM_W-1], sum_reg} + (SUM_W+1)'($signed(term));
    assign sum_ovf  = sum_wide[SUM_W] != sum_wide[SUM_W-1];
    assign sum_sat  = !sum_ovf ? sum_wide[SUM_W-1:0]
                    : (sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                       : {1'b0, {(SUM_W-1){1'b1}}});

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        axis_next     = axis_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        v_next        = v_reg;
        last_next     = last_reg;
        big_next      = big_reg;
        inner_next    = inner_reg;
        r_next        = r_reg;
        sq_next       = sq_reg;
        wx_next       = wx_reg;
        wy_next       = wy_reg;
        sum_next      = sum_reg;
        clip_next     = clip_reg;
        out_data_next = out_data_reg;
        out_sat_next  = out_sat_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        mul_req       = '{en: 1'b0, a: '0, b: '0};
        s_tready      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    dx_next    = diff_x[COORD_W] ? COORD_W'((COORD_W+1)'(0) - diff_x)
                                                 : diff_x[COORD_W-1:0];
                    dy_next    = diff_y[COORD_W] ? COORD_W'((COORD_W+1)'(0) - diff_y)
                                                 : diff_y[COORD_W-1:0];
                    v_next     = s_tdata[159:128];
                    last_next  = s_tlast;
                    axis_next  = 1'b0;
                    state_next = ST_MUL_D;
                end
            end
            ST_MUL_D: begin
                // r = d * inv_spacing
                mul_req    = '{en: 1'b1, a: (axis_reg ? dy_reg : dx_reg), b: inv_reg};
                state_next = ST_MUL_SQ;
            end
            ST_MUL_SQ: begin
                big_next   = |r_hi;
                inner_next = prod_frac <= ONE_R;
                r_next     = prod_frac;
                // r*r inside 1.0, (2-r)^2 beyond
                if (prod_frac <= ONE_R) begin
                    mul_req = '{en: 1'b1, a: MUL_W'(prod_frac), b: MUL_W'(prod_frac)};
                end else begin
                    mul_req = '{en: 1'b1, a: MUL_W'(t_wide[R_W-1:0]),
                                b: MUL_W'(t_wide[R_W-1:0])};
                end
                state_next = ST_MUL_CUBE;
            end
            ST_MUL_CUBE: begin
                sq_next = prod_frac;
                mul_req = '{en: 1'b1, a: MUL_W'(prod_frac),
                            b: MUL_W'(inner_reg ? r_reg : (r_reg - ONE_R))};
                state_next = ST_WEIGHT;
            end
            ST_WEIGHT: begin
                if (axis_reg) begin
                    wy_next    = w_calc[W_W-1:0];
                    state_next = ST_MUL_V;
                end else begin
                    wx_next    = w_calc[W_W-1:0];
                    axis_next  = 1'b1;
                    state_next = ST_MUL_D;
                end
            end
            ST_MUL_V: begin
                mul_req    = '{en: 1'b1, a: v_mag, b: MUL_W'(wx_mag[WMAG_W-1:0])};
                state_next = ST_MUL_W;
            end
            ST_MUL_W: begin
                mul_req    = '{en: 1'b1, a: prod_q, b: MUL_W'(wy_mag[WMAG_W-1:0])};
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                if (!last_reg) begin
                    sum_next   = sum_sat;
                    clip_next  = clip_reg || sum_ovf;
                    state_next = ST_IDLE;
                end else if (!(m_tvalid_reg && !m_tready)) begin
                    // output register free: emit and clear the accumulator
                    out_data_next = sum_sat;
                    out_sat_next  = clip_reg || sum_ovf;
                    m_tvalid_next = 1'b1;
                    sum_next      = '0;
                    clip_next     = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            axis_reg     <= 1'b0;
            inv_reg      <= INV_SPACING_RESET;
            sum_reg      <= '0;
            clip_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            wx_reg       <= '0;
            wy_reg       <= '0;
        end else begin
            state_reg    <= state_next;
            axis_reg     <= axis_next;
            sum_reg      <= sum_next;
            clip_reg     <= clip_next;
            m_tvalid_reg <= m_tvalid_next;
            wx_reg       <= wx_next;
            wy_reg       <= wy_next;
            if (cfg_valid) begin
                inv_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        v_reg        <= v_next;
        last_reg     <= last_next;
        big_reg      <= big_next;
        inner_reg    <= inner_next;
        r_reg        <= r_next;
        sq_reg       <= sq_next;
        out_data_reg <= out_data_next;
        out_sat_reg  <= out_sat_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_sat_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // an accepted request always starts the x distance multiply
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_MUL_D && !axis_reg))
        else $error("accepted request did not start the x weight");

    // a result only appears out of the accumulate step
    a_result_from_accum: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_ACCUM && $past(last_reg)))
        else $error("result raised outside the accumulate step");

    // kernel weights never exceed 1.0
    a_weight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ($signed(wx_reg) <= $signed(W_W'(ONE_R))) && ($signed(wy_reg) <= $signed(W_W'(ONE_R))))
        else $error("kernel weight above 1.0");

    // a pending result is never overwritten by the next emission
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("pending result overwritten");

endmodule
